// ===== design/alqd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package alqd_pkg;

    // Widths fixed by the register map and the result fields
    localparam int STEP_W     = 16;
    localparam int COUNT_W    = 8;
    localparam int DEADBAND_W = 8;
    localparam int LEVEL_W    = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STEP_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 2'd2;

    // Register reset values
    localparam logic [STEP_W-1:0]     STEP_WIDTH_RST   = 16'd64;
    localparam logic [COUNT_W-1:0]    BUCKET_COUNT_RST = 8'd16;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST     = 8'd8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture sample, evaluate deadband, start divider
        logic step;     // one restoring-division step
        logic finish;   // commit state and load result register
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/alqd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module alqd_ctrl #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          sample_valid,
    output logic               sample_ready,
    output logic               result_valid,
    input  wire logic          result_ready,
    output alqd_pkg::cmd_t     cmd
);
    import alqd_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              result_valid_reg, result_valid_next;

    // Sequence one transaction: capture, divide bit by bit, commit
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        result_valid_next = result_valid_reg;
        cmd               = '0;
        sample_ready      = 1'b0;

        // Drop the result once it has been taken
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (!result_valid_reg || result_ready)
                begin
                    cmd.finish        = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

// ===== design/alqd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module alqd_dp #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [alqd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [alqd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [SAMPLE_BITS-1:0]               sample,
    input  wire alqd_pkg::cmd_t                       cmd,
    output logic [alqd_pkg::LEVEL_W-1:0]              level,
    output logic                                      accepted
);
    import alqd_pkg::*;

    localparam int EXT_W = SAMPLE_BITS + 1;

    // Configuration registers
    logic [STEP_W-1:0]     step_width_reg;
    logic [COUNT_W-1:0]    bucket_count_reg;
    logic [DEADBAND_W-1:0] deadband_reg;

    // Kept state
    logic [SAMPLE_BITS-1:0] last_sample_reg, last_sample_next;
    logic [LEVEL_W-1:0]     last_level_reg, last_level_next;

    // Working registers
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   change_reg;
    logic [STEP_W-1:0]      rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] quot_reg, quot_next;

    // Result register
    logic [LEVEL_W-1:0] level_reg;
    logic               accepted_reg;

    logic [EXT_W-1:0]  s_ext, last_ext, db_ext;
    logic              change_now;
    logic [STEP_W:0]   trial;
    logic              trial_ge;
    logic              take;

    // Write configuration; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_width_reg   <= STEP_WIDTH_RST;
            bucket_count_reg <= BUCKET_COUNT_RST;
            deadband_reg     <= DEADBAND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_WIDTH:   step_width_reg   <= cfg_data[STEP_W-1:0];
                REG_BUCKET_COUNT: bucket_count_reg <= cfg_data[COUNT_W-1:0];
                REG_DEADBAND:     deadband_reg     <= cfg_data[DEADBAND_W-1:0];
                default:          ;
            endcase
        end
    end

    // Deadband check: outside [last - db, last + db], lower edge may go negative
    always_comb
    begin
        s_ext      = {1'b0, sample};
        last_ext   = {1'b0, last_sample_reg};
        db_ext     = EXT_W'(deadband_reg);
        change_now = ((s_ext + db_ext) < last_ext) || (s_ext > (last_ext + db_ext));
    end

    // Restoring division step: one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quot_reg[SAMPLE_BITS-1]};
        trial_ge  = trial >= {1'b0, step_width_reg};
        rem_next  = trial_ge ? STEP_W'(trial - {1'b0, step_width_reg})
                             : trial[STEP_W-1:0];
        quot_next = {quot_reg[SAMPLE_BITS-2:0], trial_ge};
    end

    // Accept when the sample moved, the step is nonzero and the bucket fits
    always_comb
    begin
        take = change_reg && (step_width_reg != '0)
               && (quot_reg < SAMPLE_BITS'(bucket_count_reg));
        last_sample_next = take ? sample_reg : last_sample_reg;
        last_level_next  = take ? LEVEL_W'(quot_reg[LEVEL_W-1:0] + 1'b1) : last_level_reg;
    end

    // Capture and iterate
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            change_reg <= change_now;
            rem_reg    <= '0;
            quot_reg   <= sample;
        end
        else if (cmd.step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    // Commit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= '0;
            last_level_reg  <= '0;
        end
        else if (cmd.finish)
        begin
            last_sample_reg <= last_sample_next;
            last_level_reg  <= last_level_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            level_reg    <= last_level_next;
            accepted_reg <= take;
        end
    end

    assign level    = level_reg;
    assign accepted = accepted_reg;

endmodule

`default_nettype wire

// ===== design/adc_level_quantizer_deadband_core.sv =====
// A sample is captured in ST_IDLE, divided in ST_DIV and committed in ST_FINISH, which loads the result register.
// One sample is in flight at a time: the next is taken only back in ST_IDLE, after the
// restoring divider has resolved its quotient one bit per cycle.
// The result sits in an output register, so the next sample is taken while it waits.
// Reset (rst_n, asynchronous, active low): step 64, 16 buckets, deadband 8,
// last sample and level cleared to zero, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module adc_level_quantizer_deadband_core #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [alqd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [alqd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              sample_valid,
    output logic                                   sample_ready,
    input  wire logic [SAMPLE_BITS-1:0]            sample,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic [alqd_pkg::LEVEL_W-1:0]           level,
    output logic                                   accepted
);
    import alqd_pkg::*;

    cmd_t cmd;

    alqd_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    alqd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .level     (level),
        .accepted  (accepted)
    );

endmodule

`default_nettype wire

// ===== design/alqd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module alqd_checker #(
    parameter int SAMPLE_BITS = 10
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              cfg_we,
    input wire logic [alqd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input wire logic [alqd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input wire logic                              sample_valid,
    input wire logic                              sample_ready,
    input wire logic [SAMPLE_BITS-1:0]            sample,
    input wire logic                              result_valid,
    input wire logic                              result_ready,
    input wire logic [alqd_pkg::LEVEL_W-1:0]      level,
    input wire logic                              accepted
);
    import alqd_pkg::*;

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(level) && $stable(accepted))
        else $error("stalled result changed or dropped");

    // One transaction in flight: busy right after taking a sample
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample taken while busy");

    // Returning to idle always presents a result
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_ready) |-> result_valid)
        else $error("idle again without a result");

    // An accepted sample always yields a nonzero level
    a_accept_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && accepted |-> level != '0)
        else $error("accepted sample with zero level");

endmodule

bind adc_level_quantizer_deadband_core alqd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_alqd_checker (.*);

`default_nettype wire

// ===== tb/tb_adc_level_quantizer_deadband_core.sv =====
`timescale 1ns / 1ps

module tb_adc_level_quantizer_deadband_core;

    import alqd_pkg::*;

    localparam int SAMPLE_BITS   = 10;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int RAND_ITEMS    = 950;
    localparam int PHASES        = 8;
    localparam int FREE_PHASE    = 2;
    localparam int HOLD_AT       = 560;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 1000;
    localparam int REPORT_MAX    = 10;
    localparam int DIR_ROWS      = 33;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [0:0] {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [SAMPLE_BITS-1:0]  smp;
        logic                    typed;
        logic [LEVEL_W-1:0]      exp_level;
        logic                    exp_acc;
    } stim_row_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               acc;
    } level_res_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   sample_valid;
    logic                   sample_ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   result_valid;
    logic                   result_ready;
    logic [LEVEL_W-1:0]     level;
    logic                   accepted;

    // Predictor copy of configuration and state
    logic [STEP_W-1:0]      q_step;
    logic [COUNT_W-1:0]     q_count;
    logic [DEADBAND_W-1:0]  q_deadband;
    logic [SAMPLE_BITS-1:0] q_last_sample;
    logic [LEVEL_W-1:0]     q_last_level;

    level_res_t pending_levels[$];
    int         mismatch_count;
    int         results_seen;
    int         stall_cycles;
    bit         free_run;

    stim_row_t directed_rows [DIR_ROWS] = '{
        // reset settings: deadband edges, lower edge below zero, full scale
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd0,    1'b1, 8'd0,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd8,    1'b1, 8'd0,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd9,    1'b1, 8'd1,  1'b1},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd1023, 1'b1, 8'd16, 1'b1},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd1015, 1'b1, 8'd16, 1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd1014, 1'b1, 8'd16, 1'b1},
        // bucket beyond count
        '{ROW_WRITE,  REG_BUCKET_COUNT, 16'd8,     10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd0,    1'b1, 8'd1,  1'b1},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd600,  1'b1, 8'd1,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd511,  1'b1, 8'd8,  1'b1},
        // zero step width
        '{ROW_WRITE,  REG_STEP_WIDTH,   16'd0,     10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd100,  1'b1, 8'd8,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd1023, 1'b1, 8'd8,  1'b0},
        // zero bucket count
        '{ROW_WRITE,  REG_STEP_WIDTH,   16'd1,     10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_WRITE,  REG_BUCKET_COUNT, 16'd0,     10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd0,    1'b1, 8'd8,  1'b0},
        // widest deadband and count
        '{ROW_WRITE,  REG_BUCKET_COUNT, 16'd255,   10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_WRITE,  REG_DEADBAND,     16'd255,   10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd256,  1'b1, 8'd8,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd255,  1'b1, 8'd8,  1'b0},
        '{ROW_WRITE,  REG_STEP_WIDTH,   16'd65535, 10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd767,  1'b1, 8'd1,  1'b1},
        // no deadband at all
        '{ROW_WRITE,  REG_DEADBAND,     16'd0,     10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_WRITE,  REG_STEP_WIDTH,   16'd4,     10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd767,  1'b1, 8'd1,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd768,  1'b0, 8'd0,  1'b0},
        // unknown index must leave the step width alone
        '{ROW_WRITE,  REG_UNUSED,       16'd0,     10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd769,  1'b0, 8'd0,  1'b0},
        // back to reset settings
        '{ROW_WRITE,  REG_STEP_WIDTH,   16'd64,    10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_WRITE,  REG_BUCKET_COUNT, 16'd16,    10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_WRITE,  REG_DEADBAND,     16'd8,     10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd0,    1'b0, 8'd0,  1'b0},
        '{ROW_SAMPLE, REG_STEP_WIDTH,   16'd0,     10'd1023, 1'b0, 8'd0,  1'b0}
    };

    adc_level_quantizer_deadband_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample      (sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .level       (level),
        .accepted    (accepted)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Quantize one sample against the deadband and advance the predicted state
    task automatic quantize_sample(input logic [SAMPLE_BITS-1:0] s, output level_res_t r);
        int          lo;
        int          hi;
        int unsigned bucket;
        lo    = int'(q_last_sample) - int'(q_deadband);
        hi    = int'(q_last_sample) + int'(q_deadband);
        r.acc = 1'b0;
        if (int'(s) < lo || int'(s) > hi)
        begin
            if (q_step != '0)
            begin
                bucket = 32'(s) / 32'(q_step);
                if (bucket < 32'(q_count))
                begin
                    q_last_sample = s;
                    q_last_level  = LEVEL_W'(bucket + 1);
                    r.acc         = 1'b1;
                end
            end
        end
        r.level = q_last_level;
    endtask

    // Pick a sample: full range, extremes, around the deadband edges or inside the deadband
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int pick;
        int base;
        int off;
        pick = $urandom_range(0, 99);
        base = int'(q_last_sample);
        if (pick < 35)
            return SAMPLE_BITS'($urandom);
        if (pick < 45)
            return ($urandom_range(0, 1) != 0) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
        if (pick < 80)
        begin
            off  = int'(q_deadband) + int'($urandom_range(0, 1));
            base = ($urandom_range(0, 1) != 0) ? base + off : base - off;
        end
        else
            base = base + int'($urandom_range(0, 2 * int'(q_deadband))) - int'(q_deadband);
        if (base < 0 || base > SAMPLE_MAX)
            return SAMPLE_BITS'($urandom);
        return SAMPLE_BITS'(base);
    endfunction

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_STEP_WIDTH:   q_step     = val[STEP_W-1:0];
            REG_BUCKET_COUNT: q_count    = val[COUNT_W-1:0];
            REG_DEADBAND:     q_deadband = val[DEADBAND_W-1:0];
            default:          ;
        endcase
    endtask

    // Offer one sample transaction and record what it should produce
    task automatic offer_sample(input logic [SAMPLE_BITS-1:0] s, input logic use_typed,
                                input level_res_t typed);
        level_res_t want;
        @(negedge clk);
        while (!free_run && $urandom_range(0, 99) < 10)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        quantize_sample(s, want);
        pending_levels.push_back(use_typed ? typed : want);
    endtask

    // Drop valid and hold until every expected result has arrived
    task automatic drain_results;
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // New random settings between phases, extremes included
    task automatic shuffle_config;
        int                    pick;
        logic [CFG_DATA_W-1:0] val;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            val = CFG_DATA_W'($urandom_range(8, 128));
        else if (pick < 80)
            val = '0;
        else if (pick < 90)
            val = '1;
        else
            val = CFG_DATA_W'($urandom);
        write_reg(REG_STEP_WIDTH, val);

        pick = $urandom_range(0, 99);
        val  = CFG_DATA_W'($urandom);
        if (pick < 60)
            val[7:0] = 8'($urandom_range(8, 64));
        else if (pick < 70)
            val[7:0] = 8'd0;
        else if (pick < 85)
            val[7:0] = 8'd255;
        write_reg(REG_BUCKET_COUNT, val);

        pick = $urandom_range(0, 99);
        val  = CFG_DATA_W'($urandom);
        if (pick < 50)
            val[7:0] = 8'($urandom_range(0, 16));
        else if (pick < 65)
            val[7:0] = 8'd0;
        else if (pick < 80)
            val[7:0] = 8'd255;
        write_reg(REG_DEADBAND, val);

        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    endtask

    task automatic note_mismatch(input level_res_t want, input logic have_want);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
        begin
            if (have_want)
                $display("mismatch at result %0d: level exp %0d got %0d, accepted exp %0b got %0b",
                         results_seen, want.level, level, want.acc, accepted);
            else
                $display("mismatch at result %0d: unexpected transaction, level %0d accepted %0b",
                         results_seen, level, accepted);
        end
    endtask

    // Check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        level_res_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (pending_levels.size() == 0)
                note_mismatch('0, 1'b0);
            else
            begin
                want = pending_levels.pop_front();
                if (level !== want.level || accepted !== want.acc)
                    note_mismatch(want, 1'b1);
            end
        end
    end

    // Receiver: random back-pressure outside the free-running phase, one long hold-off mid-run
    initial
    begin
        bit hold_done;
        hold_done    = 1'b0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_ready <= free_run ? 1'b1 : ($urandom_range(0, 99) >= 10);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Stimulus
    initial
    begin
        int         per_phase;
        level_res_t typed;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        sample_valid   = 1'b0;
        sample         = '0;
        free_run       = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        stall_cycles   = 0;
        q_step         = STEP_WIDTH_RST;
        q_count        = BUCKET_COUNT_RST;
        q_deadband     = DEADBAND_RST;
        q_last_sample  = '0;
        q_last_level   = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                typed.level = directed_rows[i].exp_level;
                typed.acc   = directed_rows[i].exp_acc;
                offer_sample(directed_rows[i].smp, directed_rows[i].typed, typed);
            end
        end

        // Random phases, each under its own settings
        per_phase = RAND_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            shuffle_config();
            free_run = (p == FREE_PHASE);
            for (int n = 0; n < per_phase; n++)
                offer_sample(pick_sample(), 1'b0, '0);
        end
        free_run = 1'b0;

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_levels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
